@@ rtl/mrwt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared types and constants for the Miller-Rabin witness test core.
// ----------------------------------------------------------------------------
package mrwt_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH + 1);

    localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [1:0] VERDICT_PRIME     = 2'd1;
    localparam logic [1:0] VERDICT_INVALID   = 2'd2;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_SHIFT = 3'd2,
        OP_MSTRT = 3'd3,
        OP_MSTEP = 3'd4,
        OP_MDONE = 3'd5
    } op_t;

    // operand choice for a modular multiply: result*result or result*base
    typedef struct packed {
        op_t  op;
        logic mul_by_base;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic d_even;
        logic is_one;
        logic is_nm1;
        logic ebit;
    } status_t;

endpackage

@@ rtl/mrwt_datapath.sv @@
// ----------------------------------------------------------------------------
// mrwt_datapath
// Operand registers and a bit-serial shift-add modular multiplier.
// ----------------------------------------------------------------------------
module mrwt_datapath (
    input  logic                       aclk,
    input  logic [mrwt_pkg::WIDTH-1:0] modulus,
    input  logic [mrwt_pkg::WIDTH-1:0] witness,
    input  logic [mrwt_pkg::CNT_W-1:0] ebit_idx,
    input  logic [mrwt_pkg::CNT_W-1:0] mbit_idx,
    input  mrwt_pkg::cmd_t             cmd,
    output mrwt_pkg::status_t          status
);
    localparam int W = mrwt_pkg::WIDTH;

    logic [W-1:0] n_reg, n_next, a_reg, a_next, d_reg, d_next;
    logic [W-1:0] x_reg, x_next, acc_reg, acc_next, y_reg, y_next;
    logic [W-1:0] nm1, dbl, sum;
    logic [W:0]   dbl_w, sum_w;

    assign nm1 = n_reg - W'(1);

    // one shift-add step: acc = 2*acc (+ x) mod n
    always_comb begin
        dbl_w = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl   = (dbl_w >= {1'b0, n_reg}) ? W'(dbl_w - {1'b0, n_reg}) : dbl_w[W-1:0];
        sum_w = {1'b0, dbl} + {1'b0, x_reg};
        sum   = (sum_w >= {1'b0, n_reg}) ? W'(sum_w - {1'b0, n_reg}) : sum_w[W-1:0];
    end

    always_comb begin
        n_next   = n_reg;
        a_next   = a_reg;
        d_next   = d_reg;
        x_next   = x_reg;
        acc_next = acc_reg;
        y_next   = y_reg;
        case (cmd.op)
            mrwt_pkg::OP_LOAD: begin
                n_next = modulus;
                a_next = witness;
                d_next = modulus - W'(1);
                // 1 mod n; n < 2 is flagged invalid anyway
                x_next = W'(1);
            end
            mrwt_pkg::OP_SHIFT: d_next = d_reg >> 1;
            mrwt_pkg::OP_MSTRT: begin
                acc_next = '0;
                y_next   = cmd.mul_by_base ? a_reg : x_reg;
            end
            mrwt_pkg::OP_MSTEP: acc_next = y_reg[mbit_idx[$clog2(W)-1:0]] ? sum : dbl;
            mrwt_pkg::OP_MDONE: x_next = acc_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    // multiplicand is x during squaring; base multiplies swap it in via y
    // (x*a == a*x, so the y operand selects which bits are scanned)
    always_comb begin
        status.invalid = (n_reg < W'(2)) || (a_reg == '0) || (a_reg >= n_reg);
        status.d_even  = (d_reg != '0) && !d_reg[0];
        status.is_one  = (x_reg == W'(1));
        status.is_nm1  = (x_reg == nm1);
        status.ebit    = d_reg[ebit_idx[$clog2(W)-1:0]];
    end

endmodule

@@ rtl/mrwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrwt_ctrl
// Sequencer: decomposition of n-1, exponent scan, squaring loop, verdict.
// ----------------------------------------------------------------------------
module mrwt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_verdict,
    output logic [mrwt_pkg::CNT_W-1:0] ebit_idx,
    output logic [mrwt_pkg::CNT_W-1:0] mbit_idx,
    output mrwt_pkg::cmd_t             cmd,
    input  mrwt_pkg::status_t          status
);
    localparam int W  = mrwt_pkg::WIDTH;
    localparam int CW = mrwt_pkg::CNT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_SPLIT = 10'b0000000100,
        S_EBIT  = 10'b0000001000,
        S_MSTRT = 10'b0000010000,
        S_MSTEP = 10'b0000100000,
        S_MDONE = 10'b0001000000,
        S_TEST  = 10'b0010000000,
        S_SQTST = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  e_reg, e_next, b_reg, b_next, s_reg, s_next, k_reg, k_next;
    logic           sq_reg, sq_next, pow_reg, pow_next;
    logic [1:0]     v_reg, v_next;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_verdict = v_reg;
    assign ebit_idx  = e_reg;
    assign mbit_idx  = b_reg;

    always_comb begin
        state_next      = state_reg;
        e_next          = e_reg;
        b_next          = b_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        sq_next         = sq_reg;
        pow_next        = pow_reg;
        v_next          = v_reg;
        cmd.op          = mrwt_pkg::OP_NONE;
        cmd.mul_by_base = !sq_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = mrwt_pkg::OP_LOAD;
                    s_next     = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.invalid) begin
                    v_next     = mrwt_pkg::VERDICT_INVALID;
                    state_next = S_OUT;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            // strip factors of two from n-1
            S_SPLIT: begin
                if (status.d_even) begin
                    cmd.op = mrwt_pkg::OP_SHIFT;
                    s_next = s_reg + CW'(1);
                end else begin
                    e_next     = CW'(W - 1);
                    pow_next   = 1'b1;
                    state_next = S_EBIT;
                end
            end
            // left-to-right exponent: square, then multiply on a set bit
            S_EBIT: begin
                sq_next    = 1'b1;
                state_next = S_MSTRT;
            end
            S_MSTRT: begin
                cmd.op     = mrwt_pkg::OP_MSTRT;
                b_next     = CW'(W - 1);
                state_next = S_MSTEP;
            end
            S_MSTEP: begin
                cmd.op = mrwt_pkg::OP_MSTEP;
                if (b_reg == '0) state_next = S_MDONE;
                else b_next = b_reg - CW'(1);
            end
            S_MDONE: begin
                cmd.op = mrwt_pkg::OP_MDONE;
                if (!pow_reg) begin
                    state_next = S_SQTST;
                end else if (sq_reg && status.ebit) begin
                    sq_next    = 1'b0;
                    state_next = S_MSTRT;
                end else if (e_reg == '0) begin
                    pow_next   = 1'b0;
                    state_next = S_TEST;
                end else begin
                    e_next     = e_reg - CW'(1);
                    state_next = S_EBIT;
                end
            end
            S_TEST: begin
                k_next  = CW'(1);
                sq_next = 1'b1;
                if (status.is_one) begin
                    v_next     = mrwt_pkg::VERDICT_PRIME;
                    state_next = S_OUT;
                end else begin
                    state_next = S_SQTST;
                end
            end
            // squaring loop; entered from S_TEST and after each square
            S_SQTST: begin
                if (status.is_nm1) begin
                    v_next     = mrwt_pkg::VERDICT_PRIME;
                    state_next = S_OUT;
                end else if (k_reg >= s_reg) begin
                    v_next     = mrwt_pkg::VERDICT_COMPOSITE;
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_MSTRT;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        e_reg   <= e_next;
        b_reg   <= b_next;
        s_reg   <= s_next;
        k_reg   <= k_next;
        sq_reg  <= sq_next;
        pow_reg <= pow_next;
        v_reg   <= v_next;
    end

endmodule

@@ rtl/miller_rabin_witness_test_core.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_core
// One Miller-Rabin round on modulus n with witness a.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | dir
//  input    | s_valid s_ready s_modulus s_witness     | in
//  result   | m_valid m_ready m_verdict               | out
//
//  One item at a time. Each modular multiply steps through S_MSTRT, S_MSTEP
//  for each multiplier bit and S_MDONE in the shift-add unit; a test runs at
//  most 2*WIDTH-1 multiplies (WIDTH squares and up to WIDTH base multiplies
//  over the exponent, then up to s-1 squares), after splitting n-1. Invalid
//  inputs go from S_CHECK straight to S_OUT. Reset is synchronous, active
//  low, and idles the sequencer. A result holds on m_verdict until m_ready
//  takes it.
module miller_rabin_witness_test_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [mrwt_pkg::WIDTH-1:0] s_modulus,
    input  logic [mrwt_pkg::WIDTH-1:0] s_witness,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_verdict
);
    mrwt_pkg::cmd_t                 cmd;
    mrwt_pkg::status_t              status;
    logic [mrwt_pkg::CNT_W-1:0]     ebit_idx, mbit_idx;

    mrwt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict),
        .ebit_idx  (ebit_idx),
        .mbit_idx  (mbit_idx),
        .cmd       (cmd),
        .status    (status)
    );

    mrwt_datapath u_dp (
        .aclk     (aclk),
        .modulus  (s_modulus),
        .witness  (s_witness),
        .ebit_idx (ebit_idx),
        .mbit_idx (mbit_idx),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ verif/miller_rabin_witness_test_core_test.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_core_test
// Self-checking bench for one Miller-Rabin round: directed corner cases, then
// random moduli and witnesses, checked against an in-bench verdict predictor.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = mrwt_pkg::WIDTH;
    localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [WIDTH-1:0] s_modulus = '0;
    logic [WIDTH-1:0] s_witness = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_verdict;

    logic [1:0]       verdict_queue[$];
    int unsigned      mismatch_count = 0;
    longint unsigned  cycle_count = 0;

    miller_rabin_witness_test_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_modulus (s_modulus),
        .s_witness (s_witness),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // (x * y) mod m via 128-bit product
    function automatic logic [WIDTH-1:0] mulmod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                                logic [WIDTH-1:0] m);
        logic [2*WIDTH-1:0] prod;
        prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
        return WIDTH'(prod % {{WIDTH{1'b0}}, m});
    endfunction

    // verdict of one round for modulus n and witness a
    function automatic logic [1:0] predict_verdict(logic [WIDTH-1:0] n, logic [WIDTH-1:0] a);
        logic [WIDTH-1:0] nm1;
        logic [WIDTH-1:0] d;
        logic [WIDTH-1:0] x;
        int               s;
        if (n < WIDTH'(2) || a == '0 || a >= n) return mrwt_pkg::VERDICT_INVALID;
        nm1 = n - WIDTH'(1);
        d   = nm1;
        s   = 0;
        while (d[0] == 1'b0) begin
            d = d >> 1;
            s++;
        end
        x = WIDTH'(1);
        for (int b = WIDTH - 1; b >= 0; b--) begin
            x = mulmod(x, x, n);
            if (d[b]) x = mulmod(x, a, n);
        end
        if (x == WIDTH'(1)) return mrwt_pkg::VERDICT_PRIME;
        for (int k = 1; k < s; k++) begin
            if (x == nm1) return mrwt_pkg::VERDICT_PRIME;
            x = mulmod(x, x, n);
        end
        return (x == nm1) ? mrwt_pkg::VERDICT_PRIME : mrwt_pkg::VERDICT_COMPOSITE;
    endfunction

    function automatic int unsigned random_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [WIDTH-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // send one item and queue its expected verdict; valid drops only over a gap
    task automatic send_item(logic [WIDTH-1:0] n, logic [WIDTH-1:0] a);
        int unsigned gap;
        gap = random_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_modulus <= n;
        s_witness <= a;
        verdict_queue.push_back(predict_verdict(n, a));
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold m_ready low for random stretches
    initial begin
        int unsigned gap;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            @(posedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                gap = random_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        logic [1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected verdict %0d with nothing pending", m_verdict);
            end else begin
                want = verdict_queue.pop_front();
                if (m_verdict !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("verdict mismatch: expected %0d, got %0d", want, m_verdict);
                end
            end
        end
    end

    // stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("miller_rabin_witness_test_core verification failed");
            $finish;
        end
    end

    task automatic test_invalid_inputs();
        send_item(0, 0);
        send_item(1, 1);
        send_item(0, 5);
        send_item(13, 0);
        send_item(13, 13);
        send_item(13, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_even_moduli();
        send_item(2, 1);
        send_item(4, 3);
        send_item(10, 3);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFD);
    endtask

    task automatic test_known_numbers();
        send_item(3, 2);
        send_item(97, 96);
        send_item(561, 2);
        send_item(2047, 2);
        send_item(221, 174);
        send_item(221, 137);
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'h1234_5678_9ABC_DEF1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555);
        send_item(64'hFFFF_FFFF_0000_0001, 2);
    endtask

    task automatic test_random_items();
        logic [WIDTH-1:0] n;
        logic [WIDTH-1:0] a;
        for (int i = 0; i < 100; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    n = random_word();
                    a = random_word();
                end
                1: begin
                    n = WIDTH'($urandom_range(0, 64));
                    a = WIDTH'($urandom_range(0, 64));
                end
                default: begin
                    n = random_word() | WIDTH'(3);
                    if ($urandom_range(0, 3) == 0) n = {32'd0, n[31:0]};
                    a = (random_word() % (n - WIDTH'(1))) + WIDTH'(1);
                end
            endcase
            send_item(n, a);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_invalid_inputs();
        test_even_moduli();
        test_known_numbers();
        test_random_items();
        s_valid <= 1'b0;
        wait (verdict_queue.size() == 0);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && verdict_queue.size() == 0)
            $display("miller_rabin_witness_test_core verification clean");
        else
            $display("miller_rabin_witness_test_core verification failed");
        $finish;
    end

endmodule
